/* sv/contact_manifold_merge_top_defines.svh */
// assertion macros for the contact manifold merge block
// no dependencies; included by the modules that carry assertions
`ifndef CONTACT_MANIFOLD_MERGE_TOP_DEFINES_SVH
`define CONTACT_MANIFOLD_MERGE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define CMM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cmm assertion failed");
// checked at every edge, reset included
`define CMM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cmm assertion failed");
`else
`define CMM_ASSERT(label, clk, rst_n, prop)
`define CMM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* sv/cmm_pkg.sv */
// shared types and constants of the contact manifold merge block
// no dependencies
package cmm_pkg;

  localparam int CacheEntries = 4;
  localparam int IdxW         = $clog2(CacheEntries);
  localparam int CountW       = $clog2(CacheEntries + 1);
  localparam int CoordW       = 24;
  localparam int DiffW        = CoordW + 1;
  localparam int ProdW        = 2 * DiffW;
  localparam int CrossW       = ProdW + 1;
  localparam int LoW          = (CrossW + 1) / 2;
  localparam int HiW          = CrossW - LoW;
  localparam int AreaW        = 2 * CrossW + 2;
  localparam int RadiusW      = 48;
  localparam logic [RadiusW-1:0] RadiusReset = 48'd6711;

  localparam logic [1:0] ActKeep    = 2'd0;
  localparam logic [1:0] ActUpdate  = 2'd1;
  localparam logic [1:0] ActAppend  = 2'd2;
  localparam logic [1:0] ActReplace = 2'd3;

  localparam logic [2:0] FlagContinued = 3'b001;
  localparam logic [2:0] FlagNew       = 3'b010;
  localparam logic [2:0] FlagReplaced  = 3'b100;

  localparam logic [1:0] CompX = 2'd0;
  localparam logic [1:0] CompY = 2'd1;
  localparam logic [1:0] CompZ = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DMUL, OP_DCMP, OP_XMUL, OP_XSQ, OP_XACC, OP_ACMP, OP_COMMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    logic [IdxW-1:0] idx;
    logic [1:0]      comp;
  } dp_cmd_t;

  typedef struct packed {
    logic have_match;
    logic full;
    logic out_free;
  } dp_stat_t;

  // corner entries of the quadrilateral left when entry k is dropped
  function automatic logic [IdxW-1:0] area_p(input logic [IdxW-1:0] k);
    return (k == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [IdxW-1:0] area_q(input logic [IdxW-1:0] k);
    return (k == 2'd3) ? 2'd2 : 2'd3;
  endfunction

  function automatic logic [IdxW-1:0] area_r(input logic [IdxW-1:0] k);
    return (k == 2'd0 || k == 2'd1) ? 2'd2 : 2'd1;
  endfunction

endpackage

/* sv/cmm_datapath.sv */
// entry storage, distance and area arithmetic, result register
// depends on cmm_pkg and contact_manifold_merge_top_defines.svh
`include "contact_manifold_merge_top_defines.svh"
module cmm_datapath import cmm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RadiusW-1:0]       cfg_wdata_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic signed [CoordW-1:0] depth_i,
  input  logic                     last_point_i,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               action_o,
  output logic [1:0]               slot_o,
  output logic [2:0]               entry_total_o,
  output logic [2:0]               pair_flags_o,
  output logic                     pair_done_o
);

  logic signed [CoordW-1:0] px_q [CacheEntries];
  logic signed [CoordW-1:0] py_q [CacheEntries];
  logic signed [CoordW-1:0] pz_q [CacheEntries];
  logic signed [CoordW-1:0] pd_q [CacheEntries];
  logic signed [CoordW-1:0] nx_q, ny_q, nz_q, nd_q;
  logic                     last_q;
  logic [CountW-1:0]        count_q;
  logic [2:0]               flag_q;
  logic [RadiusW-1:0]       radius_q;
  logic                     match_q;
  logic [IdxW-1:0]          match_idx_q;
  logic [ProdW-1:0]         sqx_q, sqy_q, sqz_q;
  logic signed [ProdW-1:0]  prod1_q, prod2_q;
  logic [2*HiW-1:0]         hh_q;
  logic [HiW+LoW-1:0]       hl_q;
  logic [2*LoW-1:0]         ll_q;
  logic [AreaW-1:0]         acc_q, best_val_q;
  logic                     best_v_q;
  logic [IdxW-1:0]          best_idx_q;
  logic                     out_valid_q;
  logic [1:0]               action_q, slot_q;
  logic [2:0]               total_q, pflags_q;
  logic                     pdone_q;

  // distance scan
  logic signed [DiffW-1:0] dx, dy, dz;
  logic signed [ProdW-1:0] sqx_w, sqy_w, sqz_w;
  logic [ProdW:0]          dist_sq;
  logic                    dist_hit;
  assign dx    = DiffW'(nx_q) - DiffW'(px_q[cmd_i.idx]);
  assign dy    = DiffW'(ny_q) - DiffW'(py_q[cmd_i.idx]);
  assign dz    = DiffW'(nz_q) - DiffW'(pz_q[cmd_i.idx]);
  assign sqx_w = dx * dx;
  assign sqy_w = dy * dy;
  assign sqz_w = dz * dz;
  assign dist_sq = (ProdW+1)'(sqx_q) + (ProdW+1)'(sqy_q) + (ProdW+1)'(sqz_q);
  // only entries below the fill level take part in the match
  assign dist_hit = (dist_sq < (ProdW+1)'(radius_q)) && (CountW'(cmd_i.idx) < count_q);

  // area terms
  logic [IdxW-1:0]         ip, iq, ir;
  logic signed [DiffW-1:0] a0, a1, a2, b0, b1, b2;
  logic signed [DiffW-1:0] m1a, m1b, m2a, m2b;
  logic signed [ProdW-1:0] m1, m2;
  logic signed [CrossW-1:0] cross_v;
  logic [CrossW-1:0]       mag;
  logic [AreaW-1:0]        sq;
  assign ip = area_p(cmd_i.idx);
  assign iq = area_q(cmd_i.idx);
  assign ir = area_r(cmd_i.idx);
  assign a0 = DiffW'(nx_q) - DiffW'(px_q[ip]);
  assign a1 = DiffW'(ny_q) - DiffW'(py_q[ip]);
  assign a2 = DiffW'(nz_q) - DiffW'(pz_q[ip]);
  assign b0 = DiffW'(px_q[iq]) - DiffW'(px_q[ir]);
  assign b1 = DiffW'(py_q[iq]) - DiffW'(py_q[ir]);
  assign b2 = DiffW'(pz_q[iq]) - DiffW'(pz_q[ir]);

  always_comb begin
    case (cmd_i.comp)
      CompX: begin
        m1a = a1; m1b = b2; m2a = a2; m2b = b1;
      end
      CompY: begin
        m1a = a2; m1b = b0; m2a = a0; m2b = b2;
      end
      default: begin
        m1a = a0; m1b = b1; m2a = a1; m2b = b0;
      end
    endcase
  end

  assign m1      = m1a * m1b;
  assign m2      = m2a * m2b;
  assign cross_v = CrossW'(prod1_q) - CrossW'(prod2_q);
  assign mag     = cross_v[CrossW-1] ? CrossW'(-cross_v) : CrossW'(cross_v);
  assign sq      = (AreaW'(hh_q) << (2 * LoW)) + (AreaW'(hl_q) << (LoW + 1)) + AreaW'(ll_q);

  // deepest entry, strictly below the new depth
  logic                     excl_v;
  logic [IdxW-1:0]          excl_idx;
  logic signed [CoordW-1:0] deepest;
  always_comb begin
    excl_v   = 1'b0;
    excl_idx = '0;
    deepest  = nd_q;
    for (int i = 0; i < CacheEntries; i++) begin
      if (pd_q[i] < deepest) begin
        excl_v   = 1'b1;
        excl_idx = IdxW'(i);
        deepest  = pd_q[i];
      end
    end
  end

  // commit decision
  logic              wr_en, upd_deep;
  logic [IdxW-1:0]   wr_slot;
  logic [1:0]        act;
  logic [2:0]        flag_new;
  logic [CountW-1:0] count_new;
  assign upd_deep = pd_q[match_idx_q] > nd_q;
  always_comb begin
    count_new = count_q;
    if (match_q) begin
      wr_slot  = match_idx_q;
      wr_en    = upd_deep;
      act      = upd_deep ? ActUpdate : ActKeep;
      flag_new = flag_q | FlagContinued;
    end else if (!stat_o.full) begin
      wr_slot   = count_q[IdxW-1:0];
      wr_en     = 1'b1;
      act       = ActAppend;
      flag_new  = flag_q | FlagNew;
      count_new = count_q + 1'b1;
    end else begin
      wr_slot  = best_idx_q;
      wr_en    = 1'b1;
      act      = ActReplace;
      flag_new = flag_q | FlagReplaced;
    end
  end

  logic commit;
  assign commit = cmd_i.op == OP_COMMIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      flag_q      <= '0;
      radius_q    <= RadiusReset;
      match_q     <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) radius_q <= cfg_wdata_i;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          match_q  <= 1'b0;
          best_v_q <= 1'b0;
        end
        OP_DCMP: begin
          if (dist_hit) begin
            match_q <= 1'b1;
          end
        end
        OP_ACMP: begin
          if (!(excl_v && excl_idx == cmd_i.idx) && (!best_v_q || acc_q > best_val_q)) begin
            best_v_q <= 1'b1;
          end
        end
        OP_COMMIT: begin
          count_q     <= count_new;
          flag_q      <= last_q ? 3'b000 : flag_new;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        nx_q   <= point_x_i;
        ny_q   <= point_y_i;
        nz_q   <= point_z_i;
        nd_q   <= depth_i;
        last_q <= last_point_i;
      end
      OP_DMUL: begin
        sqx_q <= ProdW'(sqx_w);
        sqy_q <= ProdW'(sqy_w);
        sqz_q <= ProdW'(sqz_w);
      end
      OP_DCMP: begin
        if (dist_hit) match_idx_q <= cmd_i.idx;
      end
      OP_XMUL: begin
        prod1_q <= m1;
        prod2_q <= m2;
      end
      OP_XSQ: begin
        hh_q <= mag[CrossW-1:LoW] * mag[CrossW-1:LoW];
        hl_q <= mag[CrossW-1:LoW] * mag[LoW-1:0];
        ll_q <= mag[LoW-1:0] * mag[LoW-1:0];
      end
      OP_XACC: begin
        acc_q <= (cmd_i.comp == CompX) ? sq : acc_q + sq;
      end
      OP_ACMP: begin
        if (!(excl_v && excl_idx == cmd_i.idx) && (!best_v_q || acc_q > best_val_q)) begin
          best_val_q <= acc_q;
          best_idx_q <= cmd_i.idx;
        end
      end
      OP_COMMIT: begin
        if (wr_en) begin
          px_q[wr_slot] <= nx_q;
          py_q[wr_slot] <= ny_q;
          pz_q[wr_slot] <= nz_q;
          pd_q[wr_slot] <= nd_q;
        end
        action_q <= act;
        slot_q   <= wr_slot;
        total_q  <= 3'(count_new);
        pflags_q <= flag_new;
        pdone_q  <= last_q;
      end
      default: ;
    endcase
  end

  assign stat_o.have_match = match_q;
  assign stat_o.full       = count_q == CountW'(CacheEntries);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign slot_o        = slot_q;
  assign entry_total_o = total_q;
  assign pair_flags_o  = pflags_q;
  assign pair_done_o   = pdone_q;

  `CMM_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CountW'(CacheEntries))
  `CMM_ASSERT(a_append_grows, clk_i, rst_ni,
    (commit && !match_q && !stat_o.full) |=> count_q == $past(count_q) + 1'b1)
  `CMM_ASSERT(a_flags_clear, clk_i, rst_ni, (commit && last_q) |=> flag_q == 3'b000)
  `CMM_ASSERT(a_commit_free, clk_i, rst_ni, commit |-> stat_o.out_free)

endmodule

/* sv/cmm_ctrl.sv */
// sequencer for the distance scan, area evaluation and result commit
// depends on cmm_pkg
module cmm_ctrl import cmm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DMUL, S_DCMP, S_DECIDE, S_XMUL, S_XSQ, S_XACC, S_ACMP, S_RESULT
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;
  logic [1:0]      comp_q;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    cmd_o.idx  = idx_q;
    cmd_o.comp = comp_q;
    case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_DMUL:   cmd_o.op = OP_DMUL;
      S_DCMP:   cmd_o.op = OP_DCMP;
      S_XMUL:   cmd_o.op = OP_XMUL;
      S_XSQ:    cmd_o.op = OP_XSQ;
      S_XACC:   cmd_o.op = OP_XACC;
      S_ACMP:   cmd_o.op = OP_ACMP;
      S_RESULT: cmd_o.op = stat_i.out_free ? OP_COMMIT : OP_NONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      comp_q  <= CompX;
    end else begin
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (in_valid_i) state_q <= S_DMUL;
        end
        S_DMUL: state_q <= S_DCMP;
        S_DCMP: begin
          idx_q <= idx_q + 1'b1;
          state_q <= (idx_q == IdxW'(CacheEntries - 1)) ? S_DECIDE : S_DMUL;
        end
        S_DECIDE: begin
          idx_q  <= '0;
          comp_q <= CompX;
          state_q <= (stat_i.have_match || !stat_i.full) ? S_RESULT : S_XMUL;
        end
        S_XMUL: state_q <= S_XSQ;
        S_XSQ:  state_q <= S_XACC;
        S_XACC: begin
          if (comp_q == CompZ) begin
            state_q <= S_ACMP;
          end else begin
            comp_q  <= comp_q + 1'b1;
            state_q <= S_XMUL;
          end
        end
        S_ACMP: begin
          comp_q <= CompX;
          idx_q  <= idx_q + 1'b1;
          state_q <= (idx_q == IdxW'(CacheEntries - 1)) ? S_RESULT : S_XMUL;
        end
        S_RESULT: if (stat_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/contact_manifold_merge_top.sv */
// top level of the contact manifold merge block
// depends on cmm_pkg, cmm_ctrl and cmm_datapath
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  cfg     | in        | cfg_we_i               | cfg_wdata_i (match radius squared)
//  in      | in        | in_valid_i/in_ready_o  | point, depth, tag, impulses, age, last
//  out     | out       | out_valid_o/out_ready_i| action, slot, entry_total, pair_flags
//
// after accept, a point that matches or is appended passes four distance steps
// (DMUL then DCMP per entry), a decide state and the commit state that registers it
// a replacement adds four area evaluations after the decide state: three cross
// components each through one shared multiply, square and accumulate unit, then
// an area compare; one item is in flight at a time, and the next is taken the
// cycle after the commit
// a stalled output holds the commit until the result register is free
// reset clears fill level, pair flags and output valid, and loads the radius register (6711)
module contact_manifold_merge_top import cmm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RadiusW-1:0]       cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic signed [CoordW-1:0] depth_i,
  input  logic [31:0]              contact_tag_i,
  input  logic signed [31:0]       impulse_normal_i,
  input  logic signed [31:0]       impulse_fric1_i,
  input  logic signed [31:0]       impulse_fric2_i,
  input  logic [7:0]               age_in_i,
  input  logic                     last_point_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               action_o,
  output logic [1:0]               slot_o,
  output logic [2:0]               entry_total_o,
  output logic [2:0]               pair_flags_o,
  output logic                     pair_done_o
);

  // tag, impulses and age ride along with the entry but never reach a result
  // field, so they are not stored here

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cmm_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .depth_i       (depth_i),
    .last_point_i  (last_point_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .slot_o        (slot_o),
    .entry_total_o (entry_total_o),
    .pair_flags_o  (pair_flags_o),
    .pair_done_o   (pair_done_o)
  );

endmodule
